// ----- sv/gsa_pkg.sv -----
`default_nettype none
package gsa_pkg;

	localparam logic [2:0] FUNC_CLEAR   = 3'd0;
	localparam logic [2:0] FUNC_APPEND1 = 3'd1;
	localparam logic [2:0] FUNC_APPEND2 = 3'd2;
	localparam logic [2:0] FUNC_ALIGN   = 3'd3;
	localparam logic [2:0] FUNC_FETCH   = 3'd4;

	localparam logic [1:0] CFG_MATCH    = 2'd0;
	localparam logic [1:0] CFG_MISMATCH = 2'd1;
	localparam logic [1:0] CFG_GAP      = 2'd2;

	localparam logic [1:0] DIR_DIAG = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_LEFT = 2'd2;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_NOCOL = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_ROW_RD,
		S_ROW_ST,
		S_CELL_RD,
		S_CELL_WR,
		S_FIN_RD,
		S_FIN,
		S_TB_RD,
		S_TB_WR,
		S_FETCH
	} state_t;

	typedef struct packed {
		logic       top_gap;
		logic       bottom_gap;
		logic [7:0] top;
		logic [7:0] bottom;
	} col_t;

endpackage
`default_nettype wire

// ----- sv/global_sequence_aligner_top.sv -----
// Channel  Dir  Signals                                   Word
// s        in   s_tvalid s_tready s_tdata s_tuser         one operation
// m        out  m_tvalid m_tready m_tdata m_tuser m_tlast one result
// cfg      in   cfg_valid cfg_ready cfg_index cfg_data    one register write
//
// Clear and append answer straight from idle; fetch passes through a column buffer read.
// Align initialises the score row, then fills each cell with a read and a write
// of the score row memory, then traces back and writes the columns into the column buffer.
// Reset clears lengths, counts and score and sets the score registers to defaults; memories hold no reset.
// One item at a time: s_tready is low while an item is in progress or the
// result register is full and not taken.
`default_nettype none
module global_sequence_aligner_top
	import gsa_pkg::*;
#(
	parameter int MAX_LEN = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // symbol
	input  wire logic [2:0]  s_tuser,   // func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// score[13:0] align_length[21:14] top_symbol[29:22] bottom_symbol[37:30]
	// top_gap[38] bottom_gap[39]
	output logic [39:0]      m_tdata,
	output logic [1:0]       m_tuser,   // status
	output logic             m_tlast,   // last_column
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [5:0]  cfg_data
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int DW = (MAX_LEN > 1) ? $clog2(MAX_LEN * MAX_LEN) : 1;
	localparam int BW = $clog2(2 * MAX_LEN);
	localparam int CW = $clog2(2 * MAX_LEN + 1);
	localparam int SW = $clog2(126 * MAX_LEN + 1) + 2;

	logic [7:0]          seq_a_mem [MAX_LEN];
	logic [7:0]          seq_b_mem [MAX_LEN];
	logic [SW-1:0]       row_mem   [MAX_LEN + 1];
	logic [1:0]          dir_mem   [MAX_LEN * MAX_LEN];
	col_t                col_mem   [2 * MAX_LEN];

	logic [7:0]          a_rdata_q, b_rdata_q;
	logic signed [SW-1:0] row_rdata_q;
	logic [1:0]          dir_rdata_q;
	col_t                col_rdata_q;

	state_t              state_q, state_d;
	logic [5:0]          mb_q, mp_q, gp_q;
	logic [LW-1:0]       alen_q, blen_q, i_q, j_q;
	logic [CW-1:0]       cnt_q, rp_q;
	logic [13:0]         final_q;
	logic [DW-1:0]       row_base_q;
	logic signed [SW-1:0] acc_q, bound_q, diag_q, left_q;
	logic [7:0]          sym_a_q;

	logic                m_tvalid_q;
	status_t             out_status_q;
	col_t                out_col_q;
	logic                out_last_q;
	logic [13:0]         out_score_q;
	logic [7:0]          out_len_q;

	logic                acc;
	logic                out_load, out_last;
	status_t             out_status;
	col_t                out_col;

	logic signed [SW-1:0] g_s, sc_s, d_s, u_s, l_s, best_s, bnew_s;
	logic                diag_ok;
	logic [1:0]          cell_dir, tb_dir;
	col_t                tb_col;
	logic [DW-1:0]       dir_addr;
	logic [LW-1:0]       row_raddr;
	logic [BW-1:0]       col_raddr;
	logic signed [31:0]  fin_ext;
	logic [13:0]         fin_sat;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE) && (!m_tvalid_q || m_tready);
	assign acc       = s_tvalid && s_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {out_col_q.bottom_gap, out_col_q.top_gap, out_col_q.bottom,
		out_col_q.top, out_len_q, out_score_q};

	// cell arithmetic
	assign g_s     = SW'(gp_q);
	assign sc_s    = (sym_a_q == b_rdata_q) ? SW'(mb_q) : -SW'(mp_q);
	assign d_s     = diag_q + sc_s;
	assign u_s     = row_rdata_q - g_s;
	assign l_s     = left_q - g_s;
	assign diag_ok = (d_s >= u_s) && (d_s >= l_s);
	assign best_s  = diag_ok ? d_s : ((u_s >= l_s) ? u_s : l_s);
	assign cell_dir = diag_ok ? DIR_DIAG : ((row_rdata_q > left_q) ? DIR_UP : DIR_LEFT);
	assign bnew_s  = bound_q - g_s;

	assign dir_addr  = row_base_q + DW'(j_q) - DW'(1);
	assign row_raddr = (state_q == S_FIN_RD) ? blen_q : j_q;
	assign col_raddr = BW'(cnt_q - rp_q - CW'(1));

	assign fin_ext = 32'(row_rdata_q);
	assign fin_sat = (fin_ext > 32'sd8191) ? 14'h1fff :
		(fin_ext < -32'sd8192) ? 14'h2000 : fin_ext[13:0];

	always_comb begin
		if (i_q == '0) begin
			tb_dir = DIR_LEFT;
		end else if (j_q == '0) begin
			tb_dir = DIR_UP;
		end else begin
			tb_dir = dir_rdata_q;
		end
		tb_col = '0;
		unique case (tb_dir)
			DIR_DIAG: begin
				tb_col.top    = a_rdata_q;
				tb_col.bottom = b_rdata_q;
			end
			DIR_UP: begin
				tb_col.top        = a_rdata_q;
				tb_col.bottom_gap = 1'b1;
			end
			default: begin
				tb_col.bottom  = b_rdata_q;
				tb_col.top_gap = 1'b1;
			end
		endcase
	end

	always_comb begin
		state_d    = state_q;
		out_load   = 1'b0;
		out_status = STAT_OK;
		out_col    = '0;
		out_last   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					unique case (s_tuser)
						FUNC_APPEND1: begin
							out_load = 1'b1;
							if (alen_q == LW'(MAX_LEN)) out_status = STAT_FULL;
						end
						FUNC_APPEND2: begin
							out_load = 1'b1;
							if (blen_q == LW'(MAX_LEN)) out_status = STAT_FULL;
						end
						FUNC_ALIGN: state_d = S_INIT;
						FUNC_FETCH: begin
							if (rp_q < cnt_q) begin
								state_d = S_FETCH;
							end else begin
								out_load   = 1'b1;
								out_status = STAT_NOCOL;
							end
						end
						default: out_load = 1'b1;
					endcase
				end
			end
			S_INIT: begin
				if (j_q == blen_q) state_d = (alen_q == '0) ? S_FIN_RD : S_ROW_RD;
			end
			S_ROW_RD: state_d = S_ROW_ST;
			S_ROW_ST: begin
				if (blen_q != '0) begin
					state_d = S_CELL_RD;
				end else begin
					state_d = (i_q == alen_q) ? S_FIN_RD : S_ROW_RD;
				end
			end
			S_CELL_RD: state_d = S_CELL_WR;
			S_CELL_WR: begin
				if (j_q != blen_q) begin
					state_d = S_CELL_RD;
				end else begin
					state_d = (i_q == alen_q) ? S_FIN_RD : S_ROW_RD;
				end
			end
			S_FIN_RD: state_d = S_FIN;
			S_FIN: state_d = S_TB_RD;
			S_TB_RD: begin
				if (i_q == '0 && j_q == '0) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end else begin
					state_d = S_TB_WR;
				end
			end
			S_TB_WR: state_d = S_TB_RD;
			S_FETCH: begin
				out_load = 1'b1;
				out_col  = col_rdata_q;
				out_last = (rp_q + CW'(1) == cnt_q);
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// memories: registered reads every cycle
	always_ff @(posedge clk) begin
		a_rdata_q   <= seq_a_mem[AW'(i_q - LW'(1))];
		b_rdata_q   <= seq_b_mem[AW'(j_q - LW'(1))];
		row_rdata_q <= row_mem[row_raddr];
		dir_rdata_q <= dir_mem[dir_addr];
		col_rdata_q <= col_mem[col_raddr];
		if (acc && s_tuser == FUNC_APPEND1 && alen_q != LW'(MAX_LEN)) begin
			seq_a_mem[AW'(alen_q)] <= s_tdata;
		end
		if (acc && s_tuser == FUNC_APPEND2 && blen_q != LW'(MAX_LEN)) begin
			seq_b_mem[AW'(blen_q)] <= s_tdata;
		end
		if (state_q == S_INIT) row_mem[j_q] <= acc_q;
		if (state_q == S_ROW_ST) row_mem[0] <= bnew_s;
		if (state_q == S_CELL_WR) begin
			row_mem[j_q]      <= best_s;
			dir_mem[dir_addr] <= cell_dir;
		end
		if (state_q == S_TB_WR) col_mem[BW'(cnt_q)] <= tb_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mb_q    <= 6'd2;
			mp_q    <= 6'd1;
			gp_q    <= 6'd1;
			alen_q  <= '0;
			blen_q  <= '0;
			cnt_q   <= '0;
			rp_q    <= '0;
			final_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_MATCH:    mb_q <= cfg_data;
					CFG_MISMATCH: mp_q <= cfg_data;
					CFG_GAP:      gp_q <= cfg_data;
					default: ;
				endcase
			end
			if (acc) begin
				unique case (s_tuser)
					FUNC_CLEAR: begin
						alen_q <= '0;
						blen_q <= '0;
					end
					FUNC_APPEND1: if (alen_q != LW'(MAX_LEN)) alen_q <= alen_q + LW'(1);
					FUNC_APPEND2: if (blen_q != LW'(MAX_LEN)) blen_q <= blen_q + LW'(1);
					FUNC_ALIGN: rp_q <= '0;
					default: ;
				endcase
			end
			if (state_q == S_FIN) begin
				final_q <= fin_sat;
				cnt_q   <= '0;
			end
			if (state_q == S_TB_WR) cnt_q <= cnt_q + CW'(1);
			if (state_q == S_FETCH) rp_q <= rp_q + CW'(1);
		end
	end

	// fill and traceback working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				j_q   <= '0;
				acc_q <= '0;
			end
			S_INIT: begin
				acc_q <= acc_q - g_s;
				if (j_q == blen_q) begin
					i_q        <= LW'(1);
					row_base_q <= -DW'(MAX_LEN);
					bound_q    <= '0;
				end else begin
					j_q <= j_q + LW'(1);
				end
			end
			S_ROW_ST: begin
				sym_a_q    <= a_rdata_q;
				diag_q     <= bound_q;
				bound_q    <= bnew_s;
				left_q     <= bnew_s;
				row_base_q <= row_base_q + DW'(MAX_LEN);
				j_q        <= LW'(1);
				if (blen_q == '0 && i_q != alen_q) i_q <= i_q + LW'(1);
			end
			S_CELL_WR: begin
				diag_q <= row_rdata_q;
				left_q <= best_s;
				if (j_q != blen_q) begin
					j_q <= j_q + LW'(1);
				end else if (i_q != alen_q) begin
					i_q <= i_q + LW'(1);
				end
			end
			S_FIN: begin
				i_q <= alen_q;
				j_q <= blen_q;
			end
			S_TB_WR: begin
				if (tb_dir != DIR_LEFT) begin
					i_q        <= i_q - LW'(1);
					row_base_q <= row_base_q - DW'(MAX_LEN);
				end
				if (tb_dir != DIR_UP) j_q <= j_q - LW'(1);
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= out_status;
			out_col_q    <= out_col;
			out_last_q   <= out_last;
			out_score_q  <= final_q;
			out_len_q    <= 8'(cnt_q);
		end
	end

`ifndef SYNTHESIS
	a_rp_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (rp_q <= cnt_q))
		else $error("read pointer past column count");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(2 * MAX_LEN))
		else $error("column count overflow");
	a_align_start: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s_tuser == FUNC_ALIGN) |=> (state_q == S_INIT))
		else $error("align did not start fill");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && m_tvalid_q) |-> m_tready)
		else $error("result overwritten before taken");
`endif

endmodule
`default_nettype wire
